// ----- rtl/core/tfst_pkg.sv -----
// Package with the types, codes and defaults shared by the TCP flow sequence tracker.
`default_nettype none
package tfst_pkg;

  localparam int unsigned RingDepthDef = 1024;
  localparam int unsigned HashBitsDef  = 16;
  localparam int unsigned MaxScanDef   = 256;
  localparam int unsigned ScanWinW     = 9;
  localparam logic [ScanWinW-1:0] ScanWinReset = 9'd256;
  localparam int unsigned EntryIdxW    = 10;

  localparam logic [2:0] StSynNew     = 3'd0;
  localparam logic [2:0] StRecreated  = 3'd1;
  localparam logic [2:0] StInData     = 3'd2;
  localparam logic [2:0] StInEmpty    = 3'd3;
  localparam logic [2:0] StKeepalive  = 3'd4;
  localparam logic [2:0] StRetransmit = 3'd5;
  localparam logic [2:0] StMissing    = 3'd6;

  localparam logic [1:0] KindHash  = 2'd0;
  localparam logic [1:0] KindScan  = 2'd1;
  localparam logic [1:0] KindAlloc = 2'd2;

  localparam logic [1:0] FlowClosed    = 2'd0;
  localparam logic [1:0] FlowOpened    = 2'd1;
  localparam logic [1:0] FlowDataSeen  = 2'd2;
  localparam logic [1:0] FlowRecreated = 2'd3;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_number;
    logic [15:0] seg_len;
    logic        syn_flag;
    logic        fin_flag;
  } seg_t;

  typedef struct packed {
    logic [2:0]           seq_status;
    logic [1:0]           hit_kind;
    logic [EntryIdxW-1:0] entry_index;
    logic                 first_payload;
    logic [1:0]           prior_flow_state;
    logic [31:0]          expected_seq;
    logic [15:0]          stream_offset;
  } res_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq;
    logic [15:0] pos;
    logic [1:0]  state;
  } ent_t;

  typedef struct packed {
    logic [2:0]  seq_status;
    logic        first_payload;
    logic [1:0]  prior_flow_state;
    logic [31:0] expected_seq;
    logic [15:0] stream_offset;
  } upd_t;

endpackage
`default_nettype wire

// ----- rtl/core/tfst_chan_if.sv -----
// Valid/ready channel interface with a typed payload.
`default_nettype none
interface tfst_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tcp_flow_seq_tracker_core.sv -----
// A SYN goes from its transfer to S_WRITE, a hash hit through S_HASH, S_ENT and S_WRITE;
// a hash miss then scans up to min(scan_window, MAX_SCAN) ring slots before S_WRITE.
// One segment is handled at a time; the next is taken in the cycle after the result is written,
// and a held result stalls the write-back.
// After reset a clearing pass over max(2^HASH_BITS, RING_DEPTH) addresses zeroes both memories;
// no segment is taken during it. The scan window register resets to 256.
`default_nettype none
module tcp_flow_seq_tracker_core #(
  parameter int unsigned RING_DEPTH = tfst_pkg::RingDepthDef,
  parameter int unsigned HASH_BITS  = tfst_pkg::HashBitsDef,
  parameter int unsigned MAX_SCAN   = tfst_pkg::MaxScanDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  tfst_chan_if.sink    seg_i,
  tfst_chan_if.sink    cfg_i,
  tfst_chan_if.source  res_o
);

  localparam int unsigned RW = $clog2(RING_DEPTH);
  localparam int unsigned HashSize = 1 << HASH_BITS;
  localparam int unsigned ClrN = (HashSize > RING_DEPTH) ? HashSize : RING_DEPTH;
  localparam int unsigned ClrW = $clog2(ClrN);
  localparam int unsigned LimW = $clog2(MAX_SCAN + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_ENT   = 6'b001000,
    S_SCAN  = 6'b010000,
    S_WRITE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [ClrW-1:0] clr_q, clr_d;
  logic [tfst_pkg::ScanWinW-1:0] scan_win_q;
  tfst_pkg::seg_t seg_q, seg_d;
  logic [HASH_BITS-1:0] hash_q, hash_d;
  logic [RW-1:0] cand_q, cand_d, alloc_q, alloc_d;
  logic [LimW-1:0] cnt_q, cnt_d, lim;
  logic hit_q, hit_d;
  logic [1:0] kind_q, kind_d;
  logic out_valid_q, out_valid_d;
  tfst_pkg::res_t res_q, res_d;

  tfst_pkg::ent_t ring_mem [RING_DEPTH];
  tfst_pkg::ent_t ring_rd_q, ring_wd;
  logic ring_we, ring_re;
  logic [RW-1:0] ring_wa, ring_ra;

  logic [RW-1:0] hash_mem [HashSize];
  logic [RW-1:0] hash_rd_q, hash_wd;
  logic hash_we, hash_re;
  logic [HASH_BITS-1:0] hash_wa, hash_ra;

  tfst_pkg::ent_t upd_ent;
  tfst_pkg::upd_t upd;
  logic match, seg_acc, wr_go;
  logic [RW-1:0] cand_prev;

  function automatic logic [HASH_BITS-1:0] tuple_hash(tfst_pkg::seg_t s);
    logic [19:0] h;
    h = {4'd0, s.src_addr[31:16] ^ s.dst_addr[31:16]}
        ^ (20'(s.sport) * 20'd3 + 20'(s.dport) * 20'd7);
    return HASH_BITS'(h);
  endfunction

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hash_we) begin
      hash_mem[hash_wa] <= hash_wd;
    end
    if (hash_re) begin
      hash_rd_q <= hash_mem[hash_ra];
    end
  end

  tfst_update u_update (
    .seg_i   (seg_q),
    .ent_i   (ring_rd_q),
    .alloc_i (!hit_q),
    .ent_o   (upd_ent),
    .upd_o   (upd)
  );

  assign seg_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_valid_q;
  assign res_o.data = res_q;
  assign seg_acc = seg_i.valid && seg_i.ready;
  assign wr_go = (state_q == S_WRITE) && (!out_valid_q || res_o.ready);
  assign match = (ring_rd_q.src_addr == seg_q.src_addr) && (ring_rd_q.dst_addr == seg_q.dst_addr)
                 && (ring_rd_q.sport == seg_q.sport)
                 && (ring_rd_q.dport == seg_q.dport);
  assign lim = (32'(scan_win_q) < MAX_SCAN) ? LimW'(scan_win_q) : LimW'(MAX_SCAN);
  assign cand_prev = (cand_q == '0) ? RW'(RING_DEPTH - 1) : cand_q - RW'(1);

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    seg_d = seg_q;
    hash_d = hash_q;
    cand_d = cand_q;
    alloc_d = alloc_q;
    cnt_d = cnt_q;
    hit_d = hit_q;
    kind_d = kind_q;
    out_valid_d = out_valid_q && !res_o.ready;
    res_d = res_q;
    ring_we = 1'b0;
    ring_wa = '0;
    ring_wd = '0;
    ring_re = 1'b0;
    ring_ra = cand_q;
    hash_we = 1'b0;
    hash_wa = hash_q;
    hash_wd = alloc_q;
    hash_re = 1'b0;
    hash_ra = tuple_hash(seg_i.data);
    unique case (state_q)
      S_CLEAR: begin
        ring_we = ({1'b0, clr_q} < (ClrW + 1)'(RING_DEPTH));
        ring_wa = RW'(clr_q);
        hash_we = ({1'b0, clr_q} < (ClrW + 1)'(HashSize));
        hash_wa = HASH_BITS'(clr_q);
        hash_wd = '0;
        clr_d = clr_q + ClrW'(1);
        if (clr_q == ClrW'(ClrN - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (seg_acc) begin
          seg_d = seg_i.data;
          hash_d = tuple_hash(seg_i.data);
          hash_re = 1'b1;
          hit_d = 1'b0;
          kind_d = tfst_pkg::KindAlloc;
          state_d = seg_i.data.syn_flag ? S_WRITE : S_HASH;
        end
      end
      S_HASH: begin
        ring_re = 1'b1;
        ring_ra = hash_rd_q;
        cand_d = hash_rd_q;
        state_d = S_ENT;
      end
      S_ENT: begin
        if (match) begin
          hit_d = 1'b1;
          kind_d = tfst_pkg::KindHash;
          state_d = S_WRITE;
        end else if (lim == '0) begin
          state_d = S_WRITE;
        end else begin
          ring_re = 1'b1;
          ring_ra = alloc_q;
          cand_d = alloc_q;
          cnt_d = lim;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_d = 1'b1;
          kind_d = tfst_pkg::KindScan;
          state_d = S_WRITE;
        end else if (cnt_q == LimW'(1)) begin
          state_d = S_WRITE;
        end else begin
          ring_re = 1'b1;
          ring_ra = cand_prev;
          cand_d = cand_prev;
          cnt_d = cnt_q - LimW'(1);
        end
      end
      S_WRITE: begin
        if (wr_go) begin
          ring_we = 1'b1;
          ring_wa = hit_q ? cand_q : alloc_q;
          ring_wd = upd_ent;
          if (!hit_q) begin
            hash_we = 1'b1;
            alloc_d = (alloc_q == RW'(RING_DEPTH - 1)) ? '0 : alloc_q + RW'(1);
          end
          res_d.seq_status = upd.seq_status;
          res_d.hit_kind = kind_q;
          res_d.entry_index = tfst_pkg::EntryIdxW'(hit_q ? cand_q : alloc_q);
          res_d.first_payload = upd.first_payload;
          res_d.prior_flow_state = upd.prior_flow_state;
          res_d.expected_seq = upd.expected_seq;
          res_d.stream_offset = upd.stream_offset;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      alloc_q <= '0;
      out_valid_q <= 1'b0;
      scan_win_q <= tfst_pkg::ScanWinReset;
      hit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      alloc_q <= alloc_d;
      out_valid_q <= out_valid_d;
      hit_q <= hit_d;
      if (cfg_i.valid && cfg_i.ready) begin
        scan_win_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    hash_q <= hash_d;
    cand_q <= cand_d;
    cnt_q <= cnt_d;
    kind_q <= kind_d;
    res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_alloc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(alloc_q) < RING_DEPTH)
    else $error("allocation pointer out of ring range");
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_acc |=> (state_q == S_HASH || state_q == S_WRITE))
    else $error("accepted segment did not start a lookup or allocation");
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_go |=> (out_valid_q && state_q == S_IDLE))
    else $error("completed update did not present a result");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/tfst_update.sv -----
// Sequence classification and entry update for one segment against one flow entry.
`default_nettype none
module tfst_update (
  input  tfst_pkg::seg_t seg_i,
  input  tfst_pkg::ent_t ent_i,
  input  logic           alloc_i,
  output tfst_pkg::ent_t ent_o,
  output tfst_pkg::upd_t upd_o
);

  logic [31:0] diff;

  always_comb begin
    diff = ent_i.seq - seg_i.seq_number;
    ent_o = ent_i;
    ent_o.src_addr = seg_i.src_addr;
    ent_o.dst_addr = seg_i.dst_addr;
    ent_o.sport = seg_i.sport;
    ent_o.dport = seg_i.dport;
    upd_o = '0;
    if (alloc_i) begin
      if (seg_i.syn_flag) begin
        ent_o.seq = seg_i.seq_number + 32'd1;
        ent_o.pos = '0;
        ent_o.state = tfst_pkg::FlowOpened;
        upd_o.seq_status = tfst_pkg::StSynNew;
      end else begin
        ent_o.seq = seg_i.seq_number + 32'(seg_i.seg_len);
        ent_o.pos = seg_i.seg_len;
        ent_o.state = tfst_pkg::FlowRecreated;
        upd_o.seq_status = tfst_pkg::StRecreated;
      end
    end else begin
      upd_o.prior_flow_state = ent_i.state;
      upd_o.expected_seq = ent_i.seq;
      upd_o.stream_offset = ent_i.pos;
      if (diff != 32'd0) begin
        if (seg_i.seg_len == 16'd1 && diff == 32'd1) begin
          upd_o.seq_status = tfst_pkg::StKeepalive;
        end else if (!diff[31]) begin
          upd_o.seq_status = tfst_pkg::StRetransmit;
        end else begin
          upd_o.seq_status = tfst_pkg::StMissing;
        end
      end else if (seg_i.seg_len != 16'd0) begin
        upd_o.seq_status = tfst_pkg::StInData;
        upd_o.first_payload = (ent_i.state == tfst_pkg::FlowOpened);
        ent_o.seq = ent_i.seq + 32'(seg_i.seg_len);
        ent_o.pos = ent_i.pos + seg_i.seg_len;
        ent_o.state = tfst_pkg::FlowDataSeen;
      end else begin
        upd_o.seq_status = tfst_pkg::StInEmpty;
      end
      if (seg_i.fin_flag) begin
        ent_o.seq = ent_o.seq + 32'd1;
        ent_o.state = tfst_pkg::FlowClosed;
      end
    end
  end

endmodule
`default_nettype wire
